// ===== rtl/core/d2r_pkg.sv =====
// ----------------------------------------------------------------------------
// d2r_pkg
// Shared types, constants and lookup tables for the 2x2 block to RGB decoder.
// Values are fixed point with 14 fraction bits (Q14), products and channel sums Q28.
// ----------------------------------------------------------------------------
package d2r_pkg;

  // fixed point reference levels
  localparam int OneQ14  = 16384;
  localparam int HalfQ14 = 8192;

  // number of chroma configuration registers and their index width
  localparam int NumChromaRegs = 4;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 64;

  // ycbcr-style conversion weights in q14
  localparam logic signed [15:0] KRedPr   = 16'sd22971;
  localparam logic signed [15:0] KGreenPb = 16'sd5638;
  localparam logic signed [15:0] KGreenPr = 16'sd11700;
  localparam logic signed [15:0] KBluePb  = 16'sd29032;

  // scalar types
  typedef logic [14:0]        luma_t;   // 0 .. 16384
  typedef logic signed [14:0] coef_t;   // -8192 .. 8192
  typedef logic signed [28:0] prod_t;   // weighted chroma term, |x| < 2^28
  typedef logic [3:0][CfgDataW-1:0] chroma_regs_t;

  // lookup table types
  typedef luma_t a_lut_t [64];
  typedef coef_t cos_lut_t [64];

  // dc term dequantization: (a*16384 + 31) / 63, clipped to one
  function automatic a_lut_t build_a_lut();
    a_lut_t t;
    int     v;
    for (int i = 0; i < 64; i++) begin
      v = (i * OneQ14 + 31) / 63;
      if (v > OneQ14) v = OneQ14;
      t[i] = luma_t'(v);
    end
    return t;
  endfunction

  // cosine term dequantization: v*4915/31, rounded half away from zero
  function automatic cos_lut_t build_cos_lut();
    cos_lut_t t;
    int       s;
    int       n;
    int       q;
    for (int i = 0; i < 64; i++) begin
      s = (i >= 32) ? i - 64 : i;
      n = s * 4915;
      if (n >= 0) q = (n + 15) / 31;
      else        q = -((-n + 15) / 31);
      if (q > HalfQ14)  q = HalfQ14;
      if (q < -HalfQ14) q = -HalfQ14;
      t[i] = coef_t'(q);
    end
    return t;
  endfunction

  localparam a_lut_t   ALut   = build_a_lut();
  localparam cos_lut_t CosLut = build_cos_lut();

  // stage 1: dequantized terms and chroma
  typedef struct packed {
    luma_t a;
    coef_t b;
    coef_t c;
    coef_t d;
    coef_t pb;
    coef_t pr;
  } s1_t;

  // stage 2: clipped lumas (tl, tr, bl, br) and weighted chroma terms
  typedef struct packed {
    luma_t [3:0] y;
    prod_t       r_pr;
    prod_t       g_pb;
    prod_t       g_pr;
    prod_t       b_pb;
  } s2_t;

  // stage 3: rounded q14 channels, index pixel*3 + channel
  typedef struct packed {
    luma_t [11:0] x;
  } s3_t;

  // final 8-bit channels, index pixel*3 + channel
  typedef logic [11:0][7:0] chan_t;

endpackage

// ===== rtl/core/decode_2x2_block_to_rgb_top.sv =====
// ----------------------------------------------------------------------------
// decode_2x2_block_to_rgb_top
// Decodes one packed 32-bit codeword into the RGB values of a 2x2 pixel block.
// ----------------------------------------------------------------------------
// Four-stage pipeline: unpack and table lookup, inverse transform with the
// chroma multiplies, q28 channel sums with rounding, then scaling to 8 bits
// in the output register. A codeword can be taken every cycle unless every
// stage is full and the output is stalled; each result passes through the
// stage registers in order to the outputs. The four stages each hold one
// item, so a stalled output keeps accepting input until every stage is full.
// Chroma table registers 0..3 hold sixteen signed q15 entries and should be
// written only while no codeword is in flight.
module decode_2x2_block_to_rgb_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [d2r_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [d2r_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   codeword,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    red_top_left,
  output logic [7:0]                    green_top_left,
  output logic [7:0]                    blue_top_left,
  output logic [7:0]                    red_top_right,
  output logic [7:0]                    green_top_right,
  output logic [7:0]                    blue_top_right,
  output logic [7:0]                    red_bottom_left,
  output logic [7:0]                    green_bottom_left,
  output logic [7:0]                    blue_bottom_left,
  output logic [7:0]                    red_bottom_right,
  output logic [7:0]                    green_bottom_right,
  output logic [7:0]                    blue_bottom_right
);
  import d2r_pkg::*;

  chroma_regs_t chroma_regs;

  logic  s1_valid;
  logic  s1_ready;
  s1_t   s1_data;
  logic  s2_valid;
  logic  s2_ready;
  s2_t   s2_data;
  logic  s3_valid;
  logic  s3_ready;
  s3_t   s3_data;
  chan_t chan;

  // chroma table registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_regs <= '0;
    end else if (cfg_write) begin
      chroma_regs[cfg_index] <= cfg_data;
    end
  end

  d2r_unpack u_unpack (
    .clk         (clk),
    .rst         (rst),
    .chroma_regs (chroma_regs),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .codeword    (codeword),
    .out_valid   (s1_valid),
    .out_ready   (s1_ready),
    .out_data    (s1_data)
  );

  d2r_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  d2r_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  d2r_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (chan)
  );

  // result fields, pixel-major
  assign red_top_left       = chan[0];
  assign green_top_left     = chan[1];
  assign blue_top_left      = chan[2];
  assign red_top_right      = chan[3];
  assign green_top_right    = chan[4];
  assign blue_top_right     = chan[5];
  assign red_bottom_left    = chan[6];
  assign green_bottom_left  = chan[7];
  assign blue_bottom_left   = chan[8];
  assign red_bottom_right   = chan[9];
  assign green_bottom_right = chan[10];
  assign blue_bottom_right  = chan[11];

endmodule

// ===== rtl/core/d2r_unpack.sv =====
// ----------------------------------------------------------------------------
// d2r_unpack
// Stage 1: splits the codeword, dequantizes the dc and cosine terms by
// table and looks up both chroma values in the configuration registers.
// ----------------------------------------------------------------------------
module d2r_unpack (
  input  logic                  clk,
  input  logic                  rst,
  input  d2r_pkg::chroma_regs_t chroma_regs,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           codeword,
  output logic                  out_valid,
  input  logic                  out_ready,
  output d2r_pkg::s1_t          out_data
);
  import d2r_pkg::*;

  logic valid;
  s1_t  data;
  s1_t  data_next;

  // q15 table entry to q14, floor((e+1)/2), clipped to +-0.5
  function automatic coef_t chroma_q14(input logic [15:0] u);
    logic signed [16:0] es;
    logic signed [16:0] q;
    coef_t              r;
    es = signed'({u[15], u}) + 17'sd1;
    q  = es >>> 1;
    if (q > 17'sd8192)       r = coef_t'(HalfQ14);
    else if (q < -17'sd8192) r = -coef_t'(HalfQ14);
    else                     r = q[14:0];
    return r;
  endfunction

  // entry select for a 4-bit chroma index
  function automatic logic [15:0] chroma_entry(input chroma_regs_t regs,
                                               input logic [3:0] idx);
    logic [CfgDataW-1:0] word;
    word = regs[idx[3:2]];
    return word[{idx[1:0], 4'b0000} +: 16];
  endfunction

  // field decode and table lookups
  always_comb begin
    data_next.a  = ALut[codeword[31:26]];
    data_next.b  = CosLut[codeword[25:20]];
    data_next.c  = CosLut[codeword[19:14]];
    data_next.d  = CosLut[codeword[13:8]];
    data_next.pb = chroma_q14(chroma_entry(chroma_regs, codeword[7:4]));
    data_next.pr = chroma_q14(chroma_entry(chroma_regs, codeword[3:0]));
  end

  assign in_ready = !valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

  // a transfer always lands in this stage
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid)
    else $error("d2r_unpack: accepted item lost");

  // dequantized terms stay in range
  assert property (@(posedge clk) disable iff (rst)
    valid |-> data.a <= luma_t'(OneQ14) && data.pb <= coef_t'(HalfQ14)
              && data.pb >= -coef_t'(HalfQ14) && data.pr <= coef_t'(HalfQ14)
              && data.pr >= -coef_t'(HalfQ14))
    else $error("d2r_unpack: term out of range");

endmodule

// ===== rtl/core/d2r_luma.sv =====
// ----------------------------------------------------------------------------
// d2r_luma
// Stage 2: inverse 2x2 transform with luma clipping, and the four chroma
// weight multiplications.
// ----------------------------------------------------------------------------
module d2r_luma (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  d2r_pkg::s1_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output d2r_pkg::s2_t out_data
);
  import d2r_pkg::*;

  logic valid;
  s2_t  data;
  s2_t  data_next;

  logic signed [16:0] a_s;
  logic signed [16:0] b_s;
  logic signed [16:0] c_s;
  logic signed [16:0] d_s;
  logic signed [16:0] y_raw [4];
  logic signed [30:0] p_r_pr;
  logic signed [30:0] p_g_pb;
  logic signed [30:0] p_g_pr;
  logic signed [30:0] p_b_pb;

  // clip to 0 .. one
  function automatic luma_t clip_luma(input logic signed [16:0] v);
    luma_t r;
    if (v < 17'sd0)            r = '0;
    else if (v > 17'sd16384)   r = luma_t'(OneQ14);
    else                       r = v[14:0];
    return r;
  endfunction

  // inverse transform and chroma weights
  always_comb begin
    a_s = signed'({2'b00, in_data.a});
    b_s = 17'(in_data.b);
    c_s = 17'(in_data.c);
    d_s = 17'(in_data.d);
    y_raw[0] = a_s - b_s - c_s + d_s;
    y_raw[1] = a_s - b_s + c_s - d_s;
    y_raw[2] = a_s + b_s - c_s - d_s;
    y_raw[3] = a_s + b_s + c_s + d_s;
    for (int k = 0; k < 4; k++) begin
      data_next.y[k] = clip_luma(y_raw[k]);
    end

    // chroma weights
    p_r_pr = KRedPr   * in_data.pr;
    p_g_pb = KGreenPb * in_data.pb;
    p_g_pr = KGreenPr * in_data.pr;
    p_b_pb = KBluePb  * in_data.pb;
    data_next.r_pr = p_r_pr[28:0];
    data_next.g_pb = p_g_pb[28:0];
    data_next.g_pr = p_g_pr[28:0];
    data_next.b_pb = p_b_pb[28:0];
  end

  assign in_ready = !valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

  // lumas are clipped to one
  assert property (@(posedge clk) disable iff (rst)
    valid |-> data.y[0] <= luma_t'(OneQ14) && data.y[1] <= luma_t'(OneQ14)
              && data.y[2] <= luma_t'(OneQ14) && data.y[3] <= luma_t'(OneQ14))
    else $error("d2r_luma: luma above one");

endmodule

// ===== rtl/core/d2r_mix.sv =====
// ----------------------------------------------------------------------------
// d2r_mix
// Stage 3: forms the q28 red, green and blue sums for each pixel, clips
// them to 0..1 and rounds back to q14.
// ----------------------------------------------------------------------------
module d2r_mix (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  d2r_pkg::s2_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output d2r_pkg::s3_t out_data
);
  import d2r_pkg::*;

  logic valid;
  s3_t  data;
  s3_t  data_next;

  logic signed [30:0] yq [4];
  logic signed [30:0] r_pr_s;
  logic signed [30:0] g_pb_s;
  logic signed [30:0] g_pr_s;
  logic signed [30:0] b_pb_s;

  // clip a q28 sum to 0 .. 2^28 and round to q14
  function automatic luma_t round_q14(input logic signed [30:0] s);
    logic [28:0] c;
    logic [29:0] t;
    if (s < 31'sd0)                  c = '0;
    else if (s > 31'sd268435456)     c = 29'h1000_0000;
    else                             c = s[28:0];
    t = 30'(c) + 30'd8192;
    return t[28:14];
  endfunction

  // per-pixel channel sums
  always_comb begin
    r_pr_s = 31'(in_data.r_pr);
    g_pb_s = 31'(in_data.g_pb);
    g_pr_s = 31'(in_data.g_pr);
    b_pb_s = 31'(in_data.b_pb);
    for (int k = 0; k < 4; k++) begin
      yq[k] = signed'({2'b00, in_data.y[k], 14'b0});
      data_next.x[k*3 + 0] = round_q14(yq[k] + r_pr_s);
      data_next.x[k*3 + 1] = round_q14(yq[k] - g_pb_s - g_pr_s);
      data_next.x[k*3 + 2] = round_q14(yq[k] + b_pb_s);
    end
  end

  assign in_ready = !valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

  // rounded channels 0, 4, 8 and 11 never pass one
  assert property (@(posedge clk) disable iff (rst)
    valid |-> data.x[0] <= luma_t'(OneQ14) && data.x[4] <= luma_t'(OneQ14)
              && data.x[8] <= luma_t'(OneQ14) && data.x[11] <= luma_t'(OneQ14))
    else $error("d2r_mix: channel above one");

endmodule

// ===== rtl/core/d2r_scale.sv =====
// ----------------------------------------------------------------------------
// d2r_scale
// Stage 4: scales each q14 channel by 255, truncates, saturates and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module d2r_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  d2r_pkg::s3_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output d2r_pkg::chan_t out_data
);
  import d2r_pkg::*;

  logic  valid;
  chan_t data;
  chan_t data_next;

  // x*255 >> 14 with saturation at 255
  function automatic logic [7:0] to_byte(input luma_t x);
    logic [22:0] m;
    logic [8:0]  v;
    m = {x, 8'b0} - 23'(x);
    v = m[22:14];
    return (v > 9'd255) ? 8'hff : v[7:0];
  endfunction

  // channel scaling
  always_comb begin
    for (int i = 0; i < 12; i++) begin
      data_next[i] = to_byte(in_data.x[i]);
    end
  end

  assign in_ready = !valid || out_ready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

  // an empty output register never blocks the stage before it
  assert property (@(posedge clk) disable iff (rst)
    !valid |-> in_ready)
    else $error("d2r_scale: stall with empty output");

endmodule

// ===== tb/tb_decode_2x2_block_to_rgb_top.sv =====
// ----------------------------------------------------------------------------
// tb_decode_2x2_block_to_rgb_top
// Self-checking testbench for the 2x2 block to RGB decoder. Codewords are
// sent over a valid/ready channel with random gaps. An in-bench fixed point
// decoder predicts the twelve 8-bit channels of every block, and each
// output transfer is compared channel by channel with the oldest
// prediction. The chroma table is reloaded between phases, covering the
// reset value, clipping entries and random contents. Long output stalls and
// sender pauses are included.
// ----------------------------------------------------------------------------
module tb_decode_2x2_block_to_rgb_top;
  import d2r_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxGap     = 16;

  // chroma table register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CHROMA_TABLE_0,
    CHROMA_TABLE_1,
    CHROMA_TABLE_2,
    CHROMA_TABLE_3
  } chroma_reg_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         codeword;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          red_top_left;
  logic [7:0]          green_top_left;
  logic [7:0]          blue_top_left;
  logic [7:0]          red_top_right;
  logic [7:0]          green_top_right;
  logic [7:0]          blue_top_right;
  logic [7:0]          red_bottom_left;
  logic [7:0]          green_bottom_left;
  logic [7:0]          blue_bottom_left;
  logic [7:0]          red_bottom_right;
  logic [7:0]          green_bottom_right;
  logic [7:0]          blue_bottom_right;

  // predictor state and scoreboard
  chroma_regs_t chroma_model;
  chan_t        expected_pixels [$];
  int           error_count;
  int           cycle_count;

  // idling controls shared with the receiver process
  bit           sender_idle;
  bit           receiver_idle;
  int           hold_request;

  string color_names [3] = '{"red", "green", "blue"};
  string pixel_names [4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};

  decode_2x2_block_to_rgb_top uut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .codeword           (codeword),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .red_top_left       (red_top_left),
    .green_top_left     (green_top_left),
    .blue_top_left      (blue_top_left),
    .red_top_right      (red_top_right),
    .green_top_right    (green_top_right),
    .blue_top_right     (blue_top_right),
    .red_bottom_left    (red_bottom_left),
    .green_bottom_left  (green_bottom_left),
    .blue_bottom_left   (blue_bottom_left),
    .red_bottom_right   (red_bottom_right),
    .green_bottom_right (green_bottom_right),
    .blue_bottom_right  (blue_bottom_right)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // fixed point decoder
  // ---------------------------------------------------------------------------

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // 6-bit signed cosine term to q14, rounded half away from zero
  function automatic longint cos_term(input logic [5:0] field);
    longint v;
    longint n;
    longint q;
    v = longint'(field);
    if (v >= 32) v = v - 64;
    n = v * 4915;
    if (n >= 0) q = (n + 15) / 31;
    else q = -((-n + 15) / 31);
    return clip(q, -HalfQ14, HalfQ14);
  endfunction

  // q15 table entry to q14 chroma, clipped to half
  function automatic longint chroma_value(input logic [3:0] idx);
    logic [15:0] entry;
    longint      biased;
    entry  = chroma_model[idx[3:2]][int'(idx[1:0]) * 16 +: 16];
    biased = longint'(entry ^ 16'h8000);
    return clip((biased + 1) / 2 - OneQ14, -HalfQ14, HalfQ14);
  endfunction

  // q28 sum to an 8-bit channel
  function automatic logic [7:0] channel_of_sum(input longint s);
    longint c;
    longint x;
    longint v;
    c = clip(s, 0, longint'(1) << 28);
    x = (c + HalfQ14) >> 14;
    v = (x * 255) >> 14;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic chan_t decode_block(input logic [31:0] word);
    longint dc;
    longint b;
    longint c;
    longint d;
    longint pb;
    longint pr;
    longint yq;
    longint y [4];
    chan_t  px;
    dc = clip((longint'(word[31:26]) * OneQ14 + 31) / 63, 0, OneQ14);
    b  = cos_term(word[25:20]);
    c  = cos_term(word[19:14]);
    d  = cos_term(word[13:8]);
    pb = chroma_value(word[7:4]);
    pr = chroma_value(word[3:0]);
    y[0] = dc - b - c + d;
    y[1] = dc - b + c - d;
    y[2] = dc + b - c - d;
    y[3] = dc + b + c + d;
    for (int k = 0; k < 4; k++) begin
      yq = clip(y[k], 0, OneQ14) * OneQ14;
      px[k*3 + 0] = channel_of_sum(yq + longint'(KRedPr) * pr);
      px[k*3 + 1] = channel_of_sum(yq - longint'(KGreenPb) * pb - longint'(KGreenPr) * pr);
      px[k*3 + 2] = channel_of_sum(yq + longint'(KBluePb) * pb);
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pack_codeword(input logic [5:0] a, input logic [5:0] b,
                                                input logic [5:0] c, input logic [5:0] d,
                                                input logic [3:0] pb, input logic [3:0] pr);
    return {a, b, c, d, pb, pr};
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // cosine field biased toward its extremes
  function automatic logic [5:0] pick_cos_field();
    case ($urandom_range(0, 5))
      0: return 6'h1f;
      1: return 6'h20;
      2: return 6'h00;
      3: return 6'h3f;
      default: return 6'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_codeword();
    logic [5:0] a;
    if ($urandom_range(0, 3) != 0) return $urandom;
    case ($urandom_range(0, 2))
      0: a = 6'd0;
      1: a = 6'd63;
      default: a = 6'($urandom);
    endcase
    return pack_codeword(a, pick_cos_field(), pick_cos_field(), pick_cos_field(),
                         4'($urandom), 4'($urandom));
  endfunction

  // random table, either any pattern or entries within half scale
  function automatic chroma_regs_t random_chroma_table(input bit in_range);
    chroma_regs_t t;
    int           e;
    for (int i = 0; i < 16; i++) begin
      e = in_range ? int'($urandom_range(0, 32768)) - 16384 : int'($urandom_range(0, 65535));
      t[i / 4][(i % 4) * 16 +: 16] = e[15:0];
    end
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // write all four table registers back to back; only called with nothing in flight
  task automatic load_chroma_table(input chroma_regs_t values);
    chroma_reg_t r;
    r = r.first();
    repeat (NumChromaRegs) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data  <= values[r];
      chroma_model[r] = values[r];
      r = r.next();
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // one codeword transfer, prediction queued at the accepting edge
  task automatic send_codeword(input logic [31:0] word);
    int gap;
    gap = sender_idle ? draw_gap() : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    codeword <= word;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(decode_block(word));
  endtask

  // stop sending and wait until every queued block has come out
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // table still at its reset value: pure gray output
  task automatic test_reset_table();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    send_codeword(pack_codeword(6'd0, 6'h00, 6'h00, 6'h00, 4'd0, 4'd0));
    send_codeword(pack_codeword(6'd63, 6'h00, 6'h00, 6'h00, 4'd15, 4'd15));
    send_codeword(pack_codeword(6'd40, 6'h1f, 6'h20, 6'h3f, 4'd5, 4'd10));
    wait_for_results();
  endtask

  // field extremes, every chroma index, entries at and beyond half scale
  task automatic test_field_extremes();
    chroma_regs_t t;
    t[CHROMA_TABLE_0] = 64'h4000_8000_7fff_0000;
    t[CHROMA_TABLE_1] = 64'h0001_bfff_4001_c000;
    t[CHROMA_TABLE_2] = 64'h3fff_e000_2000_ffff;
    t[CHROMA_TABLE_3] = 64'h6000_edcb_1234_c001;
    load_chroma_table(t);
    send_codeword(pack_codeword(6'd0,  6'h00, 6'h00, 6'h00, 4'd0, 4'd0));
    send_codeword(pack_codeword(6'd63, 6'h00, 6'h00, 6'h00, 4'd0, 4'd0));
    send_codeword(pack_codeword(6'd63, 6'h1f, 6'h1f, 6'h1f, 4'd0, 4'd0));
    send_codeword(pack_codeword(6'd0,  6'h20, 6'h20, 6'h20, 4'd0, 4'd0));
    send_codeword(pack_codeword(6'd32, 6'h3f, 6'h01, 6'h20, 4'd0, 4'd0));
    send_codeword(pack_codeword(6'd32, 6'h1f, 6'h20, 6'h01, 4'd0, 4'd0));
    // chroma beyond half scale on both pb and pr
    send_codeword(pack_codeword(6'd63, 6'h00, 6'h00, 6'h00, 4'd1, 4'd1));
    send_codeword(pack_codeword(6'd63, 6'h00, 6'h00, 6'h00, 4'd2, 4'd2));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd1, 4'd2));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd2, 4'd1));
    send_codeword(pack_codeword(6'd0,  6'h00, 6'h00, 6'h00, 4'd1, 4'd1));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd15, 4'd15));
    // remaining indices
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd3, 4'd4));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd5, 4'd6));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd7, 4'd8));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd9, 4'd10));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd11, 4'd12));
    send_codeword(pack_codeword(6'd32, 6'h00, 6'h00, 6'h00, 4'd13, 4'd14));
    send_codeword(pack_codeword(6'd63, 6'h1f, 6'h20, 6'h1f, 4'd15, 4'd0));
    send_codeword(32'hffff_ffff);
    send_codeword(32'haaaa_aaaa);
    send_codeword(32'h5555_5555);
    wait_for_results();
  endtask

  // several table settings with random blocks and random idling
  task automatic test_random_tables();
    chroma_regs_t t;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: t = {16{16'h7fff}};
        2: t = {16{16'h8000}};
        3: t = random_chroma_table(1'b1);
        5: t = '0;
        default: t = random_chroma_table(1'b0);
      endcase
      load_chroma_table(t);
      for (int n = 0; n < 90; n++) begin
        if (n % 15 == 0) begin
          sender_idle   = ($urandom_range(0, 3) != 0);
          receiver_idle = ($urandom_range(0, 3) != 0);
        end
        send_codeword(random_codeword());
      end
      wait_for_results();
    end
  endtask

  // back to back transfers on both sides
  task automatic test_full_rate();
    load_chroma_table(random_chroma_table(1'b0));
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    repeat (80) send_codeword(random_codeword());
    wait_for_results();
  endtask

  // long output stall while codewords keep coming, so the pipeline backs up
  task automatic test_output_stall();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_request  = 80;
    repeat (40) send_codeword(random_codeword());
    wait_for_results();
  endtask

  // short bursts, each one fully drained before the next
  task automatic test_sender_pause();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (5) begin
      repeat (10) send_codeword(random_codeword());
      wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    codeword      = '0;
    chroma_model  = '0;
    error_count   = 0;
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_request  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_table();
    test_field_extremes();
    test_random_tables();
    test_full_rate();
    test_output_stall();
    test_sender_pause();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d blocks never came out", expected_pixels.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver: random stall before each transfer, or a long requested hold
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = receiver_idle ? draw_gap() : 0;
      end
      repeat (stall) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // check every output transfer against the oldest prediction
  always @(posedge clk) begin
    chan_t got;
    chan_t want;
    if (!rst && out_valid && out_ready) begin
      got = {blue_bottom_right, green_bottom_right, red_bottom_right,
             blue_bottom_left,  green_bottom_left,  red_bottom_left,
             blue_top_right,    green_top_right,    red_top_right,
             blue_top_left,     green_top_left,     red_top_left};
      if (expected_pixels.size() == 0) begin
        report_mismatch("output transfer with no block pending");
      end else begin
        want = expected_pixels.pop_front();
        for (int k = 0; k < 12; k++) begin
          if (got[k] !== want[k])
            report_mismatch($sformatf("%s_%s: got %0d, predicted %0d",
                                      color_names[k % 3], pixel_names[k / 3],
                                      got[k], want[k]));
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/d2r_pkg.sv
rtl/core/d2r_unpack.sv
rtl/core/d2r_luma.sv
rtl/core/d2r_mix.sv
rtl/core/d2r_scale.sv
rtl/core/decode_2x2_block_to_rgb_top.sv
tb/tb_decode_2x2_block_to_rgb_top.sv
